// ===== rtl/core/utfv_pkg.sv =====
// ============================================================================
// utfv_pkg: shared types and constants for the UTF-8 string validator
// Holds the decoder state record, the byte-class constants and the small
// lead/continuation check functions used by the byte checker.
// ============================================================================
`default_nettype none

package utfv_pkg;

    // Decoder state carried from one byte to the next
    typedef struct packed {
        logic       failed;
        logic [1:0] remaining;
        logic [7:0] lead;
    } utfv_state_t;

    // Result produced by one byte
    typedef struct packed {
        logic emit;
        logic verdict;
    } utfv_result_t;

    localparam logic [7:0]  MASK_TWO      = 8'hE0;
    localparam logic [7:0]  LEAD_TWO      = 8'hC0;
    localparam logic [7:0]  MASK_THREE    = 8'hF0;
    localparam logic [7:0]  LEAD_THREE    = 8'hE0;
    localparam logic [7:0]  MASK_FOUR     = 8'hF8;
    localparam logic [7:0]  LEAD_FOUR     = 8'hF0;
    localparam logic [7:0]  CONT_MARK     = 8'h80;
    localparam logic [7:0]  MIN_TWO_LEAD  = 8'hC2;
    localparam logic [7:0]  MAX_FOUR_LEAD = 8'hF4;
    localparam logic [7:0]  LEAD_E0       = 8'hE0;
    localparam logic [7:0]  LEAD_ED       = 8'hED;
    localparam logic [7:0]  LEAD_F0       = 8'hF0;
    localparam logic [7:0]  LEAD_F4       = 8'hF4;
    localparam logic [7:0]  CONT_A0       = 8'hA0;
    localparam logic [7:0]  CONT_90       = 8'h90;
    localparam logic [7:0]  CONT_8F       = 8'h8F;
    localparam logic [10:0] MAX_SMALL_CP  = 11'h5FF;

    // Number of continuation bytes that follow a lead byte
    function automatic logic [1:0] tail_len(input logic [7:0] lead);
        logic [1:0] len;
        begin
            if (lead >= LEAD_FOUR) begin
                len = 2'd3;
            end else if (lead >= LEAD_THREE) begin
                len = 2'd2;
            end else begin
                len = 2'd1;
            end
            return len;
        end
    endfunction

    // Lead byte acceptance, restricted mode rejects three and four byte leads
    function automatic logic lead_ok(input logic [7:0] b, input logic restrict_two);
        logic ok;
        begin
            if ((b & MASK_TWO) == LEAD_TWO) begin
                ok = (b >= MIN_TWO_LEAD);
            end else if (restrict_two) begin
                ok = 1'b0;
            end else if ((b & MASK_THREE) == LEAD_THREE) begin
                ok = 1'b1;
            end else if ((b & MASK_FOUR) == LEAD_FOUR) begin
                ok = (b <= MAX_FOUR_LEAD);
            end else begin
                ok = 1'b0;
            end
            return ok;
        end
    endfunction

    // Range checks on the first continuation byte of a sequence
    function automatic logic first_cont_ok(input logic [7:0] lead, input logic [7:0] b);
        logic [10:0] cp;
        logic        ok;
        begin
            cp = {lead[4:0], b[5:0]};
            ok = 1'b1;
            if ((lead & MASK_TWO) == LEAD_TWO) begin
                ok = (cp > MAX_SMALL_CP);
            end else if (lead == LEAD_E0 && b < CONT_A0) begin
                ok = 1'b0;
            end else if (lead == LEAD_ED && b >= CONT_A0) begin
                ok = 1'b0;
            end else if (lead == LEAD_F0 && b < CONT_90) begin
                ok = 1'b0;
            end else if (lead == LEAD_F4 && b > CONT_8F) begin
                ok = 1'b0;
            end
            return ok;
        end
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/utfv_byte_check.sv =====
// ============================================================================
// utfv_byte_check: per-byte UTF-8 decoder step
// Combinational next-state and verdict logic for one string byte.
// ============================================================================
`default_nettype none

module utfv_byte_check
    import utfv_pkg::*;
(
    input  wire logic [7:0]   text_byte,
    input  wire logic         restrict_two,
    input  wire utfv_state_t  state_cur,
    output utfv_state_t       state_nxt,
    output utfv_result_t      result
);

    // Decode one byte against the current sequence state
    always_comb
    begin
        state_nxt      = state_cur;
        result.emit    = 1'b0;
        result.verdict = 1'b0;
        priority if (text_byte == 8'h00)
        begin
            // terminator: give the verdict and clear for the next string
            result.emit    = 1'b1;
            result.verdict = !state_cur.failed && (state_cur.remaining == 2'd0);
            state_nxt      = '0;
        end
        else if (state_cur.failed)
        begin
            // sticky failure: drop the byte
            state_nxt = state_cur;
        end
        else if (state_cur.remaining == 2'd0)
        begin
            if (text_byte[7] == 1'b0)
            begin
                state_nxt = state_cur;
            end
            else if (!lead_ok(text_byte, restrict_two))
            begin
                state_nxt.failed = 1'b1;
            end
            else
            begin
                state_nxt.lead      = text_byte;
                state_nxt.remaining = tail_len(text_byte);
            end
        end
        else
        begin
            if ((text_byte & MASK_TWO[7:0] & 8'hC0) != CONT_MARK)
            begin
                state_nxt.failed = 1'b1;
            end
            else if (state_cur.remaining == tail_len(state_cur.lead)
                     && !first_cont_ok(state_cur.lead, text_byte))
            begin
                state_nxt.failed = 1'b1;
            end
            else
            begin
                state_nxt.remaining = state_cur.remaining - 2'd1;
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/utfv_out_reg.sv =====
// ============================================================================
// utfv_out_reg: result register
// Holds one verdict until the downstream side takes it.
// ============================================================================
`default_nettype none

module utfv_out_reg
    import utfv_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         load,
    input  wire utfv_result_t result,
    output logic              free,
    output logic              out_valid,
    input  wire logic         out_stall,
    output logic              string_valid
);

    logic valid_reg;
    logic valid_next;
    logic verdict_reg;

    // Slot is free when empty or being taken this cycle
    assign free = !valid_reg || !out_stall;

    always_comb
    begin
        valid_next = valid_reg;
        if (free)
        begin
            valid_next = load && result.emit;
        end
    end

    // Hold the valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Capture the verdict when a new request enters the slot
    always_ff @(posedge clk)
    begin
        if (free && load && result.emit)
        begin
            verdict_reg <= result.verdict;
        end
    end

    assign out_valid    = valid_reg;
    assign string_valid = verdict_reg;

endmodule

`default_nettype wire

// ===== rtl/core/utf8_string_validator_top.sv =====
// ============================================================================
// utf8_string_validator_top: streaming UTF-8 string validator
// Checks a zero-terminated byte string and reports one verdict per string.
// ============================================================================
//
//  channel | handshake              | payload
//  --------+------------------------+---------------------------
//  input   | in_valid / in_stall    | text_byte[7:0]
//  output  | out_valid / out_stall  | string_valid
//  config  | cfg_valid / cfg_ready  | restrict_two_byte
//
//  One byte per cycle while in_stall is low. A byte is registered on accept
//  and decoded in the following cycle against the sequence state. A
//  terminator's verdict then enters the result register once the slot is
//  free, and out_valid rises with it.
//  Only a terminator waiting on a full, stalled result register stalls input.
//  Reset clears the sequence state, the mode flag and both valid flags.
// ============================================================================
`default_nettype none

module utf8_string_validator_top
    import utfv_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic [7:0] text_byte,
    output logic            out_valid,
    input  wire logic       out_stall,
    output logic            string_valid,
    input  wire logic       cfg_valid,
    output logic            cfg_ready,
    input  wire logic       restrict_two_byte
);

    logic         restrict_reg;
    logic         byte_valid_reg;
    logic         byte_valid_next;
    logic [7:0]   byte_reg;
    utfv_state_t  state_reg;
    utfv_state_t  state_next;
    utfv_state_t  state_dec;
    utfv_result_t result;
    logic         out_free;
    logic         advance;
    logic         in_take;

    assign cfg_ready = 1'b1;

    // Mode register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            restrict_reg <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            restrict_reg <= restrict_two_byte;
        end
    end

    // Decode the registered byte
    utfv_byte_check u_check (
        .text_byte    (byte_reg),
        .restrict_two (restrict_reg),
        .state_cur    (state_reg),
        .state_nxt    (state_dec),
        .result       (result)
    );

    // Advance unless a terminator is blocked by a full result slot
    assign advance  = byte_valid_reg && (!result.emit || out_free);
    assign in_stall = byte_valid_reg && !advance;
    assign in_take  = in_valid && !in_stall;

    always_comb
    begin
        byte_valid_next = byte_valid_reg;
        state_next      = state_reg;
        if (advance)
        begin
            state_next      = state_dec;
            byte_valid_next = 1'b0;
        end
        if (in_take)
        begin
            byte_valid_next = 1'b1;
        end
    end

    // Input and sequence state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_valid_reg <= 1'b0;
            state_reg      <= '0;
        end
        else
        begin
            byte_valid_reg <= byte_valid_next;
            state_reg      <= state_next;
        end
    end

    // Capture the incoming byte
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            byte_reg <= text_byte;
        end
    end

    // Result register
    utfv_out_reg u_out (
        .clk          (clk),
        .rst_n        (rst_n),
        .load         (advance),
        .result       (result),
        .free         (out_free),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .string_valid (string_valid)
    );

endmodule

`default_nettype wire

// ===== rtl/core/utfv_checker.sv =====
// ============================================================================
// utfv_checker: port-level checks for the UTF-8 string validator
// Watches the top-level handshakes and relates verdicts to terminators.
// ============================================================================
`default_nettype none

module utfv_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       in_valid,
    input wire logic       in_stall,
    input wire logic [7:0] text_byte,
    input wire logic       out_valid,
    input wire logic       out_stall,
    input wire logic       string_valid
);

    // A stalled verdict holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(string_valid))
        else $error("stalled verdict changed");

    // A fresh verdict follows an accepted terminator
    a_verdict_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && !in_stall && (text_byte == 8'h00), 2))
        else $error("verdict without a terminator");

    // Input stalls only behind a blocked verdict
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled with free output");

    // A verdict leaves only when taken
    a_out_leave: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(out_valid) |-> $past(!out_stall))
        else $error("verdict dropped");

endmodule

bind utf8_string_validator_top utfv_checker u_utfv_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .text_byte    (text_byte),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .string_valid (string_valid)
);

`default_nettype wire
